// File: src/five_point_stencil_filter_assert.svh
// ----------------------------------------------------------------------------
// Five-point stencil filter: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FIVE_POINT_STENCIL_FILTER_ASSERT_SVH
`define FIVE_POINT_STENCIL_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FPSF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("five-point stencil check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FPSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("five-point stencil check failed");

`endif

// File: src/fpsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Five-point stencil filter: package
// Register codes, field widths and reset values.
// ----------------------------------------------------------------------------
package fpsf_pkg;

    localparam int unsigned WEIGHT_BITS    = 16;
    localparam int unsigned DIM_BITS       = 11;
    localparam int unsigned DIM_MIN        = 3;
    localparam int unsigned OUT_BITS       = 42;
    localparam int unsigned OUT_TDATA_BITS = 48;
    localparam int unsigned CFG_IDX_BITS   = 3;
    localparam int unsigned CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WEIGHT_CENTER = 3'd0,
        CFG_WEIGHT_UP     = 3'd1,
        CFG_WEIGHT_DOWN   = 3'd2,
        CFG_WEIGHT_LEFT   = 3'd3,
        CFG_WEIGHT_RIGHT  = 3'd4,
        CFG_GRID_WIDTH    = 3'd5,
        CFG_GRID_HEIGHT   = 3'd6
    } t_cfg_index;

    typedef logic signed [WEIGHT_BITS-1:0] t_weight;
    typedef logic [DIM_BITS-1:0]           t_dim;

    localparam t_weight RST_WEIGHT_CENTER = 16'sd1;
    localparam t_weight RST_WEIGHT_UP     = 16'sd2;
    localparam t_weight RST_WEIGHT_DOWN   = 16'sd3;
    localparam t_weight RST_WEIGHT_LEFT   = 16'sd4;
    localparam t_weight RST_WEIGHT_RIGHT  = 16'sd5;
    localparam t_dim    RST_GRID_WIDTH    = 11'd1024;
    localparam t_dim    RST_GRID_HEIGHT   = 11'd1024;

endpackage

// File: src/five_point_stencil_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Five-point stencil filter
// Streaming weighted five-point sum over a raster grid of signed samples.
// ----------------------------------------------------------------------------
// Samples enter in raster order, one request per cycle, with tuser marking the
// first sample of a frame. When the sample at row r, column c arrives (both at
// least 2), one result leaves for interior point (r-1, c-1): the exact sum
// wc*C + wu*U + wd*D + wl*L + wr*R, kept to 42 bits; border points give none,
// and tlast flags the result of the last interior point. Throughput is one
// sample per cycle while the output is not stalled. The rate is set by the
// two line buffers, each a RAM with one read and one write a cycle, and by
// the row of five tap cells, each with one 16-bit by sample multiplier. Each
// pipeline stage advances on its own, so bubbles are squeezed out and the
// input keeps taking requests while a result waits, as long as a slot
// downstream is free. Line buffers are not cleared after reset: no result
// reads an entry that the current frame has not written. Width is clamped to
// [3, MAX_WIDTH], height raised to at least 3. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module five_point_stencil_filter #(
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned SAMPLE_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // configuration write port
    input  logic                                      i_cfg_we,
    input  logic [fpsf_pkg::CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [fpsf_pkg::CFG_DATA_BITS-1:0]        i_cfg_data,
    // sample stream in
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          i_s_axis_tdata,  // [SB-1:0] sample
    input  logic                                      i_s_axis_tuser,  // [0] frame_start
    // result stream out
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    output logic [fpsf_pkg::OUT_TDATA_BITS-1:0]       o_m_axis_tdata,  // [41:0] filtered
    output logic                                      o_m_axis_tlast   // frame_done
);

    localparam int unsigned CW   = $clog2(MAX_WIDTH);       // column index bits
    localparam int unsigned WEW  = $clog2(MAX_WIDTH + 1);   // effective width bits
    localparam int unsigned PW   = SAMPLE_BITS + fpsf_pkg::WEIGHT_BITS;
    localparam int unsigned SUMW = (PW + 3 > fpsf_pkg::OUT_BITS) ? PW + 3
                                                                 : fpsf_pkg::OUT_BITS;
    localparam int unsigned DB   = fpsf_pkg::DIM_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    fpsf_pkg::t_weight r_weight_center;
    fpsf_pkg::t_weight r_weight_up;
    fpsf_pkg::t_weight r_weight_down;
    fpsf_pkg::t_weight r_weight_left;
    fpsf_pkg::t_weight r_weight_right;
    fpsf_pkg::t_dim    r_grid_width;
    fpsf_pkg::t_dim    r_grid_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_center <= fpsf_pkg::RST_WEIGHT_CENTER;
            r_weight_up     <= fpsf_pkg::RST_WEIGHT_UP;
            r_weight_down   <= fpsf_pkg::RST_WEIGHT_DOWN;
            r_weight_left   <= fpsf_pkg::RST_WEIGHT_LEFT;
            r_weight_right  <= fpsf_pkg::RST_WEIGHT_RIGHT;
            r_grid_width    <= fpsf_pkg::RST_GRID_WIDTH;
            r_grid_height   <= fpsf_pkg::RST_GRID_HEIGHT;
        end else if (i_cfg_we) begin
            case (fpsf_pkg::t_cfg_index'(i_cfg_index))
                fpsf_pkg::CFG_WEIGHT_CENTER: begin
                    r_weight_center <= fpsf_pkg::t_weight'(i_cfg_data);
                end
                fpsf_pkg::CFG_WEIGHT_UP: begin
                    r_weight_up <= fpsf_pkg::t_weight'(i_cfg_data);
                end
                fpsf_pkg::CFG_WEIGHT_DOWN: begin
                    r_weight_down <= fpsf_pkg::t_weight'(i_cfg_data);
                end
                fpsf_pkg::CFG_WEIGHT_LEFT: begin
                    r_weight_left <= fpsf_pkg::t_weight'(i_cfg_data);
                end
                fpsf_pkg::CFG_WEIGHT_RIGHT: begin
                    r_weight_right <= fpsf_pkg::t_weight'(i_cfg_data);
                end
                fpsf_pkg::CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[DB-1:0];
                end
                fpsf_pkg::CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[DB-1:0];
                end
                default: begin
                    // unused indexes are ignored
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: each slot moves when the one after it is free or moving
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_out_valid;
    logic en_out, en3, en2, in_ready, accept, move1;

    assign en_out   = !r_out_valid || i_m_axis_tready;
    assign en3      = !r_v3 || en_out;
    assign en2      = !r_v2 || en3;
    assign in_ready = !r_v1 || en2;
    assign accept   = i_s_axis_tvalid && in_ready;
    assign move1    = r_v1 && en2;

    // ------------------------------------------------------------------
    // Stage 0: raster position of the incoming sample
    // ------------------------------------------------------------------
    logic [WEW-1:0] w_eff;
    logic [DB-1:0]  h_eff;
    logic [DB-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic [DB-1:0]  row_pre, pos_row;
    logic [CW-1:0]  col_pre, pos_col;
    logic           pos_emit, pos_last;
    logic signed [SAMPLE_BITS-1:0] in_sample;

    assign in_sample = $signed(i_s_axis_tdata[SAMPLE_BITS-1:0]);

    always_comb begin
        if (32'(r_grid_width) < fpsf_pkg::DIM_MIN) begin
            w_eff = WEW'(fpsf_pkg::DIM_MIN);
        end else if (32'(r_grid_width) > MAX_WIDTH) begin
            w_eff = WEW'(MAX_WIDTH);
        end else begin
            w_eff = WEW'(r_grid_width);
        end
        if (32'(r_grid_height) < fpsf_pkg::DIM_MIN) begin
            h_eff = DB'(fpsf_pkg::DIM_MIN);
        end else begin
            h_eff = r_grid_height;
        end
    end

    always_comb begin
        // frame start restarts the raster
        row_pre = i_s_axis_tuser ? '0 : r_row;
        col_pre = i_s_axis_tuser ? '0 : r_col;
        pos_row = row_pre;
        pos_col = col_pre;
        // a counter at or past its limit wraps (shrunk width or height)
        if (WEW'(col_pre) >= w_eff) begin
            pos_col = '0;
            pos_row = row_pre + DB'(1);
        end
        if (pos_row >= h_eff) begin
            pos_row = '0;
        end
        pos_emit = (pos_row >= DB'(2)) && (WEW'(pos_col) >= WEW'(2));
        pos_last = (pos_row == h_eff - DB'(1)) && (WEW'(pos_col) == w_eff - WEW'(1));
        // position of the following sample
        if (WEW'(pos_col) + WEW'(1) >= w_eff) begin
            n_col = '0;
            if ((DB+1)'(pos_row) + (DB+1)'(1) >= (DB+1)'(h_eff)) begin
                n_row = '0;
            end else begin
                n_row = pos_row + DB'(1);
            end
        end else begin
            n_col = CW'(WEW'(pos_col) + WEW'(1));
            n_row = pos_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers. Row one back is written with the new sample as it is
    // read (read-first); row two back takes the old row-one value a stage
    // later, so a same-address read in that cycle is forwarded.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] rd_one, rd_two;
    logic [CW-1:0]          r_s1_col;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic                   r_s1_emit, r_s1_last, r_s1_fwd;
    logic [SAMPLE_BITS-1:0] r_fwd_data;
    logic signed [SAMPLE_BITS-1:0] cur_now, up_now;

    fpsf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_one_back (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (pos_col),
        .i_wdata (in_sample),
        .i_re    (in_ready),
        .i_raddr (pos_col),
        .o_rdata (rd_one)
    );

    fpsf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_two_back (
        .i_clk   (i_clk),
        .i_we    (move1),
        .i_waddr (r_s1_col),
        .i_wdata (rd_one),
        .i_re    (in_ready),
        .i_raddr (pos_col),
        .o_rdata (rd_two)
    );

    assign cur_now = $signed(rd_one);
    assign up_now  = r_s1_fwd ? $signed(r_fwd_data) : $signed(rd_two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (in_ready) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col    <= pos_col;
            r_s1_sample <= in_sample;
            r_s1_emit   <= pos_emit;
            r_s1_last   <= pos_last;
            r_s1_fwd    <= move1 && (r_s1_col == pos_col);
            r_fwd_data  <= rd_one;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window update and products in the row of tap cells.
    // Middle row runs right -> centre -> left through the cells; the up and
    // down taps take the previous column's values.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_prev_up, r_prev_sample;
    logic signed [SAMPLE_BITS-1:0] q_right, q_centre;
    logic signed [PW-1:0] p_right, p_centre, p_left, p_up, p_down;
    logic                 r_s2_last;

    always_ff @(posedge i_clk) begin
        if (move1) begin
            r_prev_up     <= up_now;
            r_prev_sample <= r_s1_sample;
        end
    end

    fpsf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_right (
        .i_clk    (i_clk),
        .i_en     (move1),
        .i_d      (cur_now),
        .i_weight (r_weight_right),
        .o_q      (q_right),
        .o_p      (p_right)
    );

    fpsf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_centre (
        .i_clk    (i_clk),
        .i_en     (move1),
        .i_d      (q_right),
        .i_weight (r_weight_center),
        .o_q      (q_centre),
        .o_p      (p_centre)
    );

    fpsf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_left (
        .i_clk    (i_clk),
        .i_en     (move1),
        .i_d      (q_centre),
        .i_weight (r_weight_left),
        .o_q      (),
        .o_p      (p_left)
    );

    fpsf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_up (
        .i_clk    (i_clk),
        .i_en     (move1),
        .i_d      (r_prev_up),
        .i_weight (r_weight_up),
        .o_q      (),
        .o_p      (p_up)
    );

    fpsf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_down (
        .i_clk    (i_clk),
        .i_en     (move1),
        .i_d      (r_prev_sample),
        .i_weight (r_weight_down),
        .o_q      (),
        .o_p      (p_down)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= move1 && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move1) begin
            r_s2_last <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first level of the adder tree
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0] r_s3_a, r_s3_b, r_s3_c;
    logic                   r_s3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_s3_a    <= SUMW'(p_centre) + SUMW'(p_up);
            r_s3_b    <= SUMW'(p_down) + SUMW'(p_left);
            r_s3_c    <= SUMW'(p_right);
            r_s3_last <= r_s2_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: final sum into the output register
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0]              sum_all;
    logic [fpsf_pkg::OUT_BITS-1:0]       r_out_filtered;
    logic                                r_out_last;

    assign sum_all = r_s3_a + r_s3_b + r_s3_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_v3) begin
            r_out_filtered <= sum_all[fpsf_pkg::OUT_BITS-1:0];
            r_out_last     <= r_s3_last;
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(fpsf_pkg::OUT_TDATA_BITS - fpsf_pkg::OUT_BITS){1'b0}},
                              r_out_filtered};
    assign o_m_axis_tlast  = r_out_last;

endmodule

// File: src/fpsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Five-point stencil filter: generic RAM
// One write port, one read port, registered read, read-first.
// ----------------------------------------------------------------------------
module fpsf_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/fpsf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Five-point stencil filter: tap cell
// Weights the incoming sample and passes it on to the next cell.
// ----------------------------------------------------------------------------
module fpsf_cell #(
    parameter int unsigned SAMPLE_BITS = 24
) (
    input  logic                                            i_clk,
    input  logic                                            i_en,
    input  logic signed [SAMPLE_BITS-1:0]                   i_d,
    input  logic signed [fpsf_pkg::WEIGHT_BITS-1:0]         i_weight,
    output logic signed [SAMPLE_BITS-1:0]                   o_q,
    output logic signed [SAMPLE_BITS+fpsf_pkg::WEIGHT_BITS-1:0] o_p
);

    logic signed [SAMPLE_BITS-1:0]                       r_q;
    logic signed [SAMPLE_BITS+fpsf_pkg::WEIGHT_BITS-1:0] r_p;

    // product of the sample as it arrives; the held copy feeds the neighbour
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
            r_p <= i_weight * i_d;
        end
    end

    assign o_q = r_q;
    assign o_p = r_p;

endmodule

// File: src/fpsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Five-point stencil filter: port checker
// Watches the top-level ports for stall and ready behaviour.
// ----------------------------------------------------------------------------
`include "five_point_stencil_filter_assert.svh"

module fpsf_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_s_axis_tready,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [fpsf_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata,
    input logic                                 o_m_axis_tlast
);

    // a stalled result holds its payload
    `FPSF_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    // empty output register: nothing can block the pipeline
    `FPSF_ASSERT_NOW(a_ready_when_out_empty, !o_m_axis_tvalid, o_s_axis_tready)

    // downstream taking results: input never stalls
    `FPSF_ASSERT_NOW(a_ready_when_sink_ready, i_m_axis_tready, o_s_axis_tready)

endmodule

bind five_point_stencil_filter fpsf_checker u_fpsf_checker (.*);
